/* src/scan_object_segmenter_macros.svh */
// Assertion macros shared by the segmenter modules.
// No dependencies; included by files that carry concurrent checks.
`ifndef SCAN_OBJECT_SEGMENTER_MACROS_SVH
`define SCAN_OBJECT_SEGMENTER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SOS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define SOS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/sos_pkg.sv */
// Shared widths, constants and item types of the scan object segmenter.
// No dependencies; used by every module of the block but sos_ram.
package sos_pkg;

    localparam int SWEEP_SAMPLES = 91;
    localparam int IDX_W         = $clog2(SWEEP_SAMPLES);
    localparam int LEN_W         = $clog2(SWEEP_SAMPLES + 1);
    localparam int WID_W         = LEN_W + 1;

    localparam int DIST_W = 10;
    localparam int IR_W   = 12;
    localparam int ANG_W  = 8;
    localparam int LIN_W  = 12;
    localparam int CNT_W  = 6;
    localparam int THR_W  = 12;
    localparam int LIM_W  = 8;

    localparam int K_W    = 11;
    localparam int FRAC_W = 16;
    localparam int RW_W   = DIST_W + WID_W;
    localparam int PROD_W = RW_W + K_W;

    // pi/180 in Q16, rounded to nearest
    localparam logic [K_W-1:0]   DEG_TO_RAD_Q16 = 11'd1144;
    localparam logic [LIN_W-1:0] LIN_MAX        = '1;
    localparam logic [CNT_W-1:0] COUNT_MAX      = '1;
    localparam logic [ANG_W-1:0] ANG_MAX        = '1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;
    localparam int REG_IDX_W  = PADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_IR_THRESHOLD = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_SKINNY_LIMIT = 1'd1;

    localparam logic [THR_W-1:0] IR_THRESHOLD_RESET = 12'd650;
    localparam logic [LIM_W-1:0] SKINNY_LIMIT_RESET = 8'd9;

    typedef struct packed {
        logic [DIST_W-1:0] ping_distance;
        logic [IR_W-1:0]   ir_level;
        logic              last_sample;
    } t_in_item;

    typedef struct packed {
        logic              has_object;
        logic [ANG_W-1:0]  center_angle;
        logic [DIST_W-1:0] object_distance;
        logic [ANG_W-1:0]  angular_width;
        logic [LIN_W-1:0]  linear_width;
        logic              is_skinny;
        logic [CNT_W-1:0]  object_number;
        logic              scan_done;
        logic [CNT_W-1:0]  object_count;
    } t_out_item;

    // Classified result handed from front to back
    typedef struct packed {
        logic              has_object;
        logic [ANG_W-1:0]  center_angle;
        logic [DIST_W-1:0] object_distance;
        logic [LEN_W-1:0]  run_len;
        logic [CNT_W-1:0]  object_number;
        logic              scan_done;
        logic [CNT_W-1:0]  object_count;
    } t_cmd;

endpackage

/* src/sos_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sos_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* src/sos_front.sv */
// Front end: accepts samples, keeps the distance store and run state, and
// queues one command per result. Depends on sos_pkg, sos_ram and the macros.
`include "scan_object_segmenter_macros.svh"

module sos_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  sos_pkg::t_in_item             i_item,
    output logic                          o_full,
    input  logic [sos_pkg::THR_W-1:0]     i_ir_threshold,
    output logic                          o_q_push,
    output sos_pkg::t_cmd                 o_q_item,
    input  logic                          i_q_full
);

    typedef enum logic {S_IDLE, S_PUSH} t_state;

    t_state                        r_state, n_state;
    logic [sos_pkg::IDX_W-1:0]     r_sample_index, n_sample_index;
    logic                          r_in_run, n_in_run;
    logic [sos_pkg::IDX_W-1:0]     r_run_start, n_run_start;
    logic [sos_pkg::CNT_W-1:0]     r_objects, n_objects;
    logic                          r_skip, n_skip;
    sos_pkg::t_cmd                 r_cmd, n_cmd;
    logic                          r_bypass, n_bypass;
    logic [sos_pkg::DIST_W-1:0]    r_dist, n_dist;

    logic                          accept;
    logic                          at_end;
    logic                          above;
    logic                          by_low;
    logic                          closed;
    logic                          obj;
    logic                          produce;
    logic [sos_pkg::LEN_W-1:0]     end_idx;
    logic [sos_pkg::LEN_W-1:0]     run_len;
    logic [sos_pkg::LEN_W-1:0]     half_len;
    logic [sos_pkg::IDX_W-1:0]     center_idx;
    logic [sos_pkg::CNT_W-1:0]     count_after;
    logic [sos_pkg::DIST_W-1:0]    store_rdata;

    assign accept  = i_push && (r_state == S_IDLE);
    assign at_end  = i_item.last_sample
                   || (r_sample_index >= sos_pkg::IDX_W'(sos_pkg::SWEEP_SAMPLES - 1));
    assign above   = i_item.ir_level > i_ir_threshold;
    assign by_low  = r_in_run && !above;
    assign closed  = r_in_run && (!above || at_end);

    // A run closed at the end of the sweep includes the current sample
    assign end_idx  = by_low ? sos_pkg::LEN_W'(r_sample_index)
                             : sos_pkg::LEN_W'(r_sample_index) + sos_pkg::LEN_W'(1);
    assign run_len  = end_idx - sos_pkg::LEN_W'(r_run_start);
    assign half_len = sos_pkg::LEN_W'(({1'b0, run_len} + (sos_pkg::LEN_W + 1)'(1)) >> 1);
    assign center_idx = r_run_start + sos_pkg::IDX_W'(half_len);

    assign obj     = closed && (run_len >= sos_pkg::LEN_W'(2));
    assign produce = obj || at_end;

    assign count_after = (obj && (r_objects != sos_pkg::COUNT_MAX))
                       ? r_objects + sos_pkg::CNT_W'(1) : r_objects;

    sos_ram #(
        .WIDTH (sos_pkg::DIST_W),
        .DEPTH (sos_pkg::SWEEP_SAMPLES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_sample_index),
        .i_wdata (i_item.ping_distance),
        .i_re    (accept),
        .i_raddr (center_idx),
        .o_rdata (store_rdata)
    );

    always_comb begin
        n_state        = r_state;
        n_sample_index = r_sample_index;
        n_in_run       = r_in_run;
        n_run_start    = r_run_start;
        n_objects      = r_objects;
        n_skip         = r_skip;
        n_cmd          = r_cmd;
        n_bypass       = r_bypass;
        n_dist         = r_dist;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_skip = obj && by_low;
                    if (r_in_run) begin
                        if (closed) begin
                            n_in_run = 1'b0;
                        end
                    end else if (above && !r_skip && !at_end) begin
                        n_in_run    = 1'b1;
                        n_run_start = r_sample_index;
                    end

                    n_cmd                 = '0;
                    n_cmd.has_object      = obj;
                    n_cmd.scan_done       = at_end;
                    n_cmd.object_count    = count_after;
                    if (obj) begin
                        n_cmd.center_angle  = sos_pkg::ANG_W'({center_idx, 1'b0});
                        n_cmd.run_len       = run_len;
                        n_cmd.object_number = r_objects;
                    end
                    // Center on the current sample: the store read sees old data
                    n_bypass = (center_idx == r_sample_index);
                    n_dist   = i_item.ping_distance;

                    if (at_end) begin
                        n_sample_index = '0;
                        n_in_run       = 1'b0;
                        n_objects      = '0;
                        n_skip         = 1'b0;
                    end else begin
                        n_sample_index = r_sample_index + sos_pkg::IDX_W'(1);
                        n_objects      = count_after;
                    end

                    n_state = produce ? S_PUSH : S_IDLE;
                end
            end
            S_PUSH: begin
                if (!i_q_full) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_sample_index <= '0;
            r_in_run       <= 1'b0;
            r_run_start    <= '0;
            r_objects      <= '0;
            r_skip         <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_sample_index <= n_sample_index;
            r_in_run       <= n_in_run;
            r_run_start    <= n_run_start;
            r_objects      <= n_objects;
            r_skip         <= n_skip;
        end
        r_cmd    <= n_cmd;
        r_bypass <= n_bypass;
        r_dist   <= n_dist;
    end

    assign o_full   = (r_state != S_IDLE);
    assign o_q_push = (r_state == S_PUSH) && !i_q_full;

    always_comb begin
        o_q_item = r_cmd;
        if (!r_cmd.has_object) begin
            o_q_item.object_distance = '0;
        end else if (r_bypass) begin
            o_q_item.object_distance = r_dist;
        end else begin
            o_q_item.object_distance = store_rdata;
        end
    end

    `SOS_ASSERT_IMPLIES(a_index_range, i_clk, i_rst_n, 1'b1,
        r_sample_index <= sos_pkg::IDX_W'(sos_pkg::SWEEP_SAMPLES - 1), "sample index overrun")
    `SOS_ASSERT_IMPLIES(a_no_skip_in_run, i_clk, i_rst_n, r_in_run, !r_skip,
        "skip flag set during a run")
    `SOS_ASSERT_NEXT(a_sweep_restart, i_clk, i_rst_n, accept && at_end,
        (r_sample_index == '0) && !r_in_run && (r_objects == '0), "sweep state not cleared")
    `SOS_ASSERT_NEXT(a_silent_item_ready, i_clk, i_rst_n, accept && !produce, !o_full,
        "front stalled on an item without a result")
    `SOS_ASSERT_IMPLIES(a_push_has_result, i_clk, i_rst_n, r_state == S_PUSH,
        r_cmd.has_object || r_cmd.scan_done, "queued command carries no result")

endmodule

/* src/sos_cmd_queue.sv */
// Short command queue between front and back ends.
// Depends on sos_pkg.
module sos_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sos_pkg::t_cmd i_item,
    output logic          o_full,
    input  logic          i_pop,
    output sos_pkg::t_cmd o_head,
    output logic          o_empty
);

    localparam logic [sos_pkg::QPTR_W-1:0] LAST_PTR = sos_pkg::QPTR_W'(sos_pkg::QUEUE_DEPTH - 1);

    sos_pkg::t_cmd               r_mem [sos_pkg::QUEUE_DEPTH];
    logic [sos_pkg::QPTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [sos_pkg::QPTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [sos_pkg::QCNT_W-1:0]  r_count, n_count;
    logic                        do_push;
    logic                        do_pop;

    assign o_full  = (r_count == sos_pkg::QCNT_W'(sos_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + sos_pkg::QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + sos_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + sos_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - sos_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* src/sos_back.sv */
// Back end: turns queued commands into result items (width product, Q16
// scaling, saturation, skinny test). Depends on sos_pkg.
module sos_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sos_pkg::t_cmd             i_q_head,
    input  logic                      i_q_empty,
    output logic                      o_q_pop,
    input  logic [sos_pkg::LIM_W-1:0] i_skinny_limit,
    output sos_pkg::t_out_item        o_result,
    output logic                      o_empty,
    input  logic                      i_pop
);

    logic                        r_a_valid;
    sos_pkg::t_cmd               r_a_cmd;
    logic [sos_pkg::RW_W-1:0]    r_a_rw;
    logic                        r_out_valid;
    sos_pkg::t_out_item          r_out;

    logic                        out_free;
    logic                        a_free;
    logic [sos_pkg::WID_W-1:0]   head_wid;
    logic [sos_pkg::WID_W-1:0]   a_wid;
    logic [sos_pkg::PROD_W-1:0]  prod;
    logic [sos_pkg::PROD_W-1:0]  lin_full;
    logic [sos_pkg::LIN_W-1:0]   lin;
    sos_pkg::t_out_item          n_out;

    assign out_free = !r_out_valid || i_pop;
    assign a_free   = !r_a_valid || out_free;
    assign o_q_pop  = !i_q_empty && a_free;

    assign head_wid = {i_q_head.run_len, 1'b0};
    assign a_wid    = {r_a_cmd.run_len, 1'b0};

    assign prod     = sos_pkg::PROD_W'(r_a_rw) * sos_pkg::PROD_W'(sos_pkg::DEG_TO_RAD_Q16);
    assign lin_full = prod >> sos_pkg::FRAC_W;
    assign lin      = (lin_full > sos_pkg::PROD_W'(sos_pkg::LIN_MAX))
                    ? sos_pkg::LIN_MAX : lin_full[sos_pkg::LIN_W-1:0];

    always_comb begin
        n_out                 = '0;
        n_out.has_object      = r_a_cmd.has_object;
        n_out.center_angle    = r_a_cmd.center_angle;
        n_out.object_distance = r_a_cmd.object_distance;
        n_out.angular_width   = (a_wid > sos_pkg::WID_W'(sos_pkg::ANG_MAX))
                              ? sos_pkg::ANG_MAX : sos_pkg::ANG_W'(a_wid);
        n_out.linear_width    = lin;
        n_out.is_skinny       = r_a_cmd.has_object
                              && (lin <= sos_pkg::LIN_W'(i_skinny_limit));
        n_out.object_number   = r_a_cmd.object_number;
        n_out.scan_done       = r_a_cmd.scan_done;
        n_out.object_count    = r_a_cmd.object_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (a_free) begin
                r_a_valid <= !i_q_empty;
            end
            if (out_free) begin
                r_out_valid <= r_a_valid;
            end
        end
        if (o_q_pop) begin
            r_a_cmd <= i_q_head;
            r_a_rw  <= sos_pkg::RW_W'(i_q_head.object_distance) * sos_pkg::RW_W'(head_wid);
        end
        if (out_free && r_a_valid) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;
    assign o_empty  = !r_out_valid;

endmodule

/* src/scan_object_segmenter.sv */
// Top level of the scan object segmenter: configuration registers, front
// end, command queue and back end. Depends on sos_pkg and all sos_ modules.
//
//   channel   direction  handshake                 payload
//   sample    in         push / full               i_item   (t_in_item)
//   result    out        empty / pop               o_result (t_out_item)
//   config    in         psel penable pwrite       paddr, pwdata, prdata
//
// A sample that yields no result leaves the front free for the next sample; one
// that yields a result holds the front for accept with store write and read,
// then queue push. The back end registers the width product, then the Q16 scale.
// Reset clears control state only; the distance store has no clearing pass.
// A full queue holds the front; a low pop holds the back, then the queue.
module scan_object_segmenter (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    input  sos_pkg::t_in_item                 i_item,
    output logic                              full,
    output logic                              empty,
    input  logic                              pop,
    output sos_pkg::t_out_item                o_result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sos_pkg::PADDR_W-1:0]       paddr,
    input  logic [sos_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sos_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    logic [sos_pkg::THR_W-1:0]     r_ir_threshold;
    logic [sos_pkg::LIM_W-1:0]     r_skinny_limit;
    logic                          cfg_write;
    logic [sos_pkg::REG_IDX_W-1:0] reg_idx;

    logic                          q_push;
    logic                          q_full;
    logic                          q_pop;
    logic                          q_empty;
    sos_pkg::t_cmd                 q_in;
    sos_pkg::t_cmd                 q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_idx   = paddr[sos_pkg::PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ir_threshold <= sos_pkg::IR_THRESHOLD_RESET;
            r_skinny_limit <= sos_pkg::SKINNY_LIMIT_RESET;
        end else if (cfg_write) begin
            case (reg_idx)
                sos_pkg::REG_IR_THRESHOLD: r_ir_threshold <= pwdata[sos_pkg::THR_W-1:0];
                sos_pkg::REG_SKINNY_LIMIT: r_skinny_limit <= pwdata[sos_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            sos_pkg::REG_IR_THRESHOLD: prdata = sos_pkg::APB_DATA_W'(r_ir_threshold);
            sos_pkg::REG_SKINNY_LIMIT: prdata = sos_pkg::APB_DATA_W'(r_skinny_limit);
            default:                   prdata = '0;
        endcase
    end

    sos_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_item         (i_item),
        .o_full         (full),
        .i_ir_threshold (r_ir_threshold),
        .o_q_push       (q_push),
        .o_q_item       (q_in),
        .i_q_full       (q_full)
    );

    sos_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty)
    );

    sos_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_head       (q_head),
        .i_q_empty      (q_empty),
        .o_q_pop        (q_pop),
        .i_skinny_limit (r_skinny_limit),
        .o_result       (o_result),
        .o_empty        (empty),
        .i_pop          (pop)
    );

endmodule
